// File: rtl/core/rgbhsl_pkg.sv
// Package: shared types, widths and constants for the RGB to HSL converter.
`timescale 1ns / 1ps
`default_nettype none
package rgbhsl_pkg;
   localparam int FB = 12;
   localparam int CW = FB + 1;
   localparam int QW = FB + 1;
   localparam logic [CW-1:0] ONE = CW'(1) << FB;
   localparam logic [FB-1:0] THIRD = FB'((2 ** FB + 1) / 3);
   localparam logic [FB-1:0] TWO_THIRD = FB'((2 * (2 ** FB) + 1) / 3);

   typedef struct packed {
      logic [CW-1:0] red;
      logic [CW-1:0] green;
      logic [CW-1:0] blue;
   } pix_in_type;

   typedef struct packed {
      logic [FB-1:0] hue;
      logic [CW-1:0] saturation;
      logic [CW-1:0] lightness;
   } pix_out_type;

   // classified item between front and back
   typedef struct packed {
      logic          gray;
      logic          negative;
      logic [FB-1:0] offset;
      logic [CW-1:0] mag;
      logic [CW-1:0] delta;
      logic [CW-1:0] den;
      logic [CW-1:0] lightness;
   } cls_type;
endpackage
`default_nettype wire

// File: rtl/core/rgb_to_hsl_converter.sv
// Top level: RGB to HSL converter, queue-style ports on both sides.
//
//  channel | ports                          | transfer when
//  req     | req_push, req_full, req_data   | req_push && !req_full
//  rsp     | rsp_pop, rsp_empty, rsp_data   | rsp_pop && !rsp_empty
//
// One pixel per clock sustained while rsp_pop keeps up; after its input transfer
// a result passes the front register, one queue slot, the divider pipeline (a
// load stage plus 13 quotient-bit stages) and the result register to rsp_data.
// Synchronous reset clears all valid flags and queue pointers.
// A stalled result freezes the divider pipeline; the 4-entry queue and the
// front register absorb input until full rises.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsl_converter import rgbhsl_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_push,
   output logic       req_full,
   input  pix_in_type req_data,
   input  wire logic  rsp_pop,
   output logic       rsp_empty,
   output pix_out_type rsp_data
);
   logic    f_rdy, f_v, q_rdy, q_v, b_rdy, b_v;
   cls_type f_c, q_c;

   rgbhsl_front u_front (.clock, .reset, .in_valid(req_push), .in_pix(req_data),
      .in_ready(f_rdy), .out_valid(f_v), .out_cls(f_c), .out_ready(q_rdy));
   rgbhsl_queue u_queue (.clock, .reset, .in_valid(f_v), .in_cls(f_c),
      .in_ready(q_rdy), .out_valid(q_v), .out_cls(q_c), .out_ready(b_rdy));
   rgbhsl_back u_back (.clock, .reset, .in_valid(q_v), .in_cls(q_c),
      .in_ready(b_rdy), .out_valid(b_v), .out_pix(rsp_data), .out_ready(rsp_pop));

   assign req_full  = !f_rdy;
   assign rsp_empty = !b_v;

   a_no_full_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_full) else $error("full after reset");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data)) else $error("result moved");
   a_hue_gray: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.saturation == '0) |-> rsp_data.hue == '0)
      else $error("gray hue");
endmodule
`default_nettype wire

// File: rtl/core/rgbhsl_front.sv
// Front end: clamp, max/min, classification of one pixel per cycle while out_ready allows.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsl_front import rgbhsl_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  pix_in_type      in_pix,
   output logic            in_ready,
   output logic            out_valid,
   output cls_type         out_cls,
   input  wire logic       out_ready
);
   logic          valid_ff, valid_in;
   cls_type       cls_ff, cls_in;
   logic [CW-1:0] rv, gv, bv, mx, mn, pos, neg;
   logic [CW:0]   sum;

   function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
      return (v > ONE) ? ONE : v;
   endfunction

   always_comb begin
      rv = clamp(in_pix.red);
      gv = clamp(in_pix.green);
      bv = clamp(in_pix.blue);
      mx = rv;
      mn = rv;
      if (gv > mx) mx = gv;
      if (bv > mx) mx = bv;
      if (gv < mn) mn = gv;
      if (bv < mn) mn = bv;
      sum = {1'b0, mx} + {1'b0, mn};
      if (rv == mx) begin
         pos = gv; neg = bv; cls_in.offset = '0;
      end else if (gv == mx) begin
         pos = bv; neg = rv; cls_in.offset = THIRD;
      end else begin
         pos = rv; neg = gv; cls_in.offset = TWO_THIRD;
      end
      cls_in.gray      = (mx == mn);
      cls_in.negative  = neg > pos;
      cls_in.mag       = cls_in.negative ? (neg - pos) : (pos - neg);
      cls_in.delta     = mx - mn;
      cls_in.den       = (sum < {1'b0, ONE}) ? sum[CW-1:0]
                                              : CW'({ONE, 1'b0} - sum);
      cls_in.lightness = sum[CW:1];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_cls   = cls_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (in_ready && in_valid) cls_ff <= cls_in;
   end
endmodule
`default_nettype wire

// File: rtl/core/rgbhsl_queue.sv
// Short queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsl_queue import rgbhsl_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  cls_type   in_cls,
   output logic      in_ready,
   output logic      out_valid,
   output cls_type   out_cls,
   input  wire logic out_ready
);
   cls_type     mem [4];
   logic [1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign in_ready  = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign out_cls   = mem[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign wr_in     = wr_ff + 2'(push);
   assign rd_in     = rd_ff + 2'(pop);
   assign cnt_in    = cnt_ff + 3'(push) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem[wr_ff] <= in_cls;
   end
endmodule
`default_nettype wire

// File: rtl/core/rgbhsl_back.sv
// Back end: pipelined restoring dividers for saturation and hue.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsl_back import rgbhsl_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  in_valid,
   input  cls_type    in_cls,
   output logic       in_ready,
   output logic       out_valid,
   output pix_out_type out_pix,
   input  wire logic  out_ready
);
   // one quotient bit per stage, QW stages; quotients fit in QW bits
   localparam int NS = QW;
   localparam int RW = CW + 4;

   logic          v_ff [NS+1];
   cls_type       c_ff [NS+1];
   logic [RW-1:0] sr_ff [NS+1], hr_ff [NS+1];
   logic [QW-1:0] sq_ff [NS+1], hq_ff [NS+1];
   logic          adv;
   logic          res_v_ff;
   pix_out_type   res_ff, res_in;
   logic [QW-1:0] q;
   logic [FB:0]   hs;

   assign adv      = !res_v_ff || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NS; i++) v_ff[i] <= 1'b0;
         res_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= NS; i++) v_ff[i] <= v_ff[i-1];
         res_v_ff <= v_ff[NS];
      end
      if (adv) begin
         c_ff[0]  <= in_cls;
         // dividend is x*ONE; its bits above the quotient width seed the remainder
         sr_ff[0] <= RW'(in_cls.delta >> 1);
         hr_ff[0] <= RW'(in_cls.mag >> 1);
         sq_ff[0] <= '0; hq_ff[0] <= '0;
         res_ff   <= res_in;
         for (int i = 1; i <= NS; i++) begin
            logic [RW-1:0] sr, hr, hd;
            // first stage brings in bit 0 of the dividend's x, then zeros
            sr = {sr_ff[i-1][RW-2:0], (i == 1) ? c_ff[i-1].delta[0] : 1'b0};
            hr = {hr_ff[i-1][RW-2:0], (i == 1) ? c_ff[i-1].mag[0] : 1'b0};
            hd = RW'(c_ff[i-1].delta) * RW'(6);
            c_ff[i] <= c_ff[i-1];
            if (sr >= RW'(c_ff[i-1].den)) begin
               sr_ff[i] <= sr - RW'(c_ff[i-1].den);
               sq_ff[i] <= {sq_ff[i-1][QW-2:0], 1'b1};
            end else begin
               sr_ff[i] <= sr;
               sq_ff[i] <= {sq_ff[i-1][QW-2:0], 1'b0};
            end
            if (hr >= hd) begin
               hr_ff[i] <= hr - hd;
               hq_ff[i] <= {hq_ff[i-1][QW-2:0], 1'b1};
            end else begin
               hr_ff[i] <= hr;
               hq_ff[i] <= {hq_ff[i-1][QW-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      q = hq_ff[NS];
      if (!c_ff[NS].negative)
         hs = {1'b0, c_ff[NS].offset} + q;
      else if (q <= QW'(c_ff[NS].offset))
         hs = {1'b0, c_ff[NS].offset} - q;
      else
         hs = {1'b0, ONE[FB-1:0]} + {1'b0, c_ff[NS].offset} - q;
      res_in.lightness  = c_ff[NS].lightness;
      res_in.hue        = c_ff[NS].gray ? '0 : hs[FB-1:0];
      res_in.saturation = c_ff[NS].gray ? '0 : sq_ff[NS];
   end

   assign out_valid = res_v_ff;
   assign out_pix   = res_ff;
endmodule
`default_nettype wire
